FILE: hdl/sosc_pkg.sv
// Shared types and constants for the spiral-order matrix scanner.
`default_nettype none

package sosc_pkg;

  localparam int VAL_W  = 32;
  localparam int RC_W   = 3;
  localparam int ADDR_W = 7;

  typedef logic [RC_W-1:0] rc_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [VAL_W-1:0]   data;
  } wr_req_t;

  typedef struct packed {
    logic push;
    logic bank;
  } run_tok_t;

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_RIGHT,
    SP_DOWN,
    SP_LEFT,
    SP_UP
  } sp_state_t;

endpackage

`default_nettype wire

FILE: hdl/sosc_front.sv
// Load side: accepts matrix words, fills a free bank, issues a run token per full matrix.
`default_nettype none

module sosc_front #(
  parameter int DIM = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [sosc_pkg::VAL_W-1:0]  in_elem_value,
  input  wire logic                        bank_free,
  output sosc_pkg::wr_req_t                wr,
  output sosc_pkg::run_tok_t               tok
);

  localparam int CELLS = DIM * DIM;
  localparam int CNT_W = $clog2(CELLS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wb_r, wb_nxt;
  logic [1:0]       occ_r, occ_nxt;
  logic             accept;
  logic             done;

  assign in_stall = (occ_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign done     = accept && (cnt_r == CNT_W'(CELLS - 1));

  assign wr.en   = accept;
  assign wr.addr = sosc_pkg::ADDR_W'(int'(wb_r) * CELLS + int'(cnt_r));
  assign wr.data = in_elem_value;

  assign tok.push = done;
  assign tok.bank = wb_r;

  always_comb begin
    cnt_nxt = cnt_r;
    wb_nxt  = wb_r;
    if (accept) begin
      if (done) begin
        cnt_nxt = '0;
        wb_nxt  = !wb_r;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    occ_nxt = occ_r + 2'(done) - 2'(bank_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wb_r  <= 1'b0;
      occ_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      wb_r  <= wb_nxt;
      occ_r <= occ_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sosc_fifo.sv
// Two-entry queue of run tokens between the load side and the scan side.
`default_nettype none

module sosc_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sosc_pkg::run_tok_t tok,
  input  wire logic               pop,
  output logic                    empty,
  output logic                    head_bank
);

  logic       ent_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty     = (cnt_r == 2'd0);
  assign head_bank = ent_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ tok.push;
    cnt_nxt    = cnt_r + 2'(tok.push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (tok.push) begin
      ent_r[wr_ptr_r] <= tok.bank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sosc_back.sv
// Scan side: two-bank element memory, spiral walker, read stage and output register.
`default_nettype none

module sosc_back #(
  parameter int DIM = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sosc_pkg::wr_req_t          wr,
  input  wire logic                       q_empty,
  input  wire logic                       q_bank,
  output logic                            q_pop,
  output logic                            bank_free,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [sosc_pkg::VAL_W-1:0]      out_value,
  output sosc_pkg::rc_t                   out_row,
  output sosc_pkg::rc_t                   out_col,
  output logic                            out_run_last
);

  localparam int CELLS  = DIM * DIM;
  localparam int DEPTH  = 2 * CELLS;
  localparam int MEM_AW = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(CELLS + 1);

  logic [sosc_pkg::VAL_W-1:0] mem [DEPTH];

  sosc_pkg::sp_state_t state_r, state_nxt;
  sosc_pkg::rc_t       row_r, row_nxt, col_r, col_nxt;
  sosc_pkg::rc_t       top_r, top_nxt, bot_r, bot_nxt;
  sosc_pkg::rc_t       lft_r, lft_nxt, rgt_r, rgt_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                bank_r, bank_nxt;

  logic                       s1_v_r;
  sosc_pkg::rc_t              s1_row_r, s1_col_r;
  logic                       s1_last_r;
  logic [sosc_pkg::VAL_W-1:0] rd_data_r;

  logic                       out_valid_r;
  logic [sosc_pkg::VAL_W-1:0] out_value_r;
  sosc_pkg::rc_t              out_row_r, out_col_r;
  logic                       out_last_r;

  logic              adv;
  logic              issue;
  logic              last;
  logic [MEM_AW-1:0] rd_addr;

  assign adv     = !out_valid_r || !out_stall;
  assign issue   = (state_r != sosc_pkg::SP_IDLE) && (!s1_v_r || adv);
  assign last    = (k_r == CNT_W'(CELLS - 1));
  assign rd_addr = MEM_AW'(int'(bank_r) * CELLS + int'(row_r) * DIM + int'(col_r));

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    lft_nxt   = lft_r;
    rgt_nxt   = rgt_r;
    k_nxt     = k_r;
    bank_nxt  = bank_r;
    q_pop     = 1'b0;
    bank_free = 1'b0;
    if (state_r == sosc_pkg::SP_IDLE) begin
      if (!q_empty) begin
        q_pop     = 1'b1;
        bank_nxt  = q_bank;
        row_nxt   = '0;
        col_nxt   = '0;
        top_nxt   = '0;
        lft_nxt   = '0;
        bot_nxt   = sosc_pkg::RC_W'(DIM - 1);
        rgt_nxt   = sosc_pkg::RC_W'(DIM - 1);
        k_nxt     = '0;
        state_nxt = sosc_pkg::SP_RIGHT;
      end
    end else if (issue) begin
      k_nxt = k_r + CNT_W'(1);
      if (last) begin
        bank_free = 1'b1;
        state_nxt = sosc_pkg::SP_IDLE;
      end else begin
        case (state_r)
          sosc_pkg::SP_RIGHT: begin
            if (col_r == rgt_r) begin
              top_nxt   = top_r + sosc_pkg::RC_W'(1);
              row_nxt   = row_r + sosc_pkg::RC_W'(1);
              state_nxt = sosc_pkg::SP_DOWN;
            end else begin
              col_nxt = col_r + sosc_pkg::RC_W'(1);
            end
          end
          sosc_pkg::SP_DOWN: begin
            if (row_r == bot_r) begin
              rgt_nxt   = rgt_r - sosc_pkg::RC_W'(1);
              col_nxt   = col_r - sosc_pkg::RC_W'(1);
              state_nxt = sosc_pkg::SP_LEFT;
            end else begin
              row_nxt = row_r + sosc_pkg::RC_W'(1);
            end
          end
          sosc_pkg::SP_LEFT: begin
            if (col_r == lft_r) begin
              bot_nxt   = bot_r - sosc_pkg::RC_W'(1);
              row_nxt   = row_r - sosc_pkg::RC_W'(1);
              state_nxt = sosc_pkg::SP_UP;
            end else begin
              col_nxt = col_r - sosc_pkg::RC_W'(1);
            end
          end
          sosc_pkg::SP_UP: begin
            if (row_r == top_r) begin
              lft_nxt   = lft_r + sosc_pkg::RC_W'(1);
              col_nxt   = col_r + sosc_pkg::RC_W'(1);
              state_nxt = sosc_pkg::SP_RIGHT;
            end else begin
              row_nxt = row_r - sosc_pkg::RC_W'(1);
            end
          end
          default: begin
            state_nxt = sosc_pkg::SP_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sosc_pkg::SP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    top_r  <= top_nxt;
    bot_r  <= bot_nxt;
    lft_r  <= lft_nxt;
    rgt_r  <= rgt_nxt;
    k_r    <= k_nxt;
    bank_r <= bank_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[MEM_AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_addr];
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_last_r <= last;
    end
    if (adv && s1_v_r) begin
      out_value_r <= rd_data_r;
      out_row_r   <= s1_row_r;
      out_col_r   <= s1_col_r;
      out_last_r  <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_run_last = out_last_r;

endmodule

`default_nettype wire

FILE: hdl/spiral_order_matrix_scan_core.sv
// Top level of the spiral-order matrix scanner.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_elem_value
//   out      output     out_valid / out_stall out_value, out_row, out_col, out_run_last
//
// One word is loaded per cycle into a two-bank memory while in_stall is low; a
// full DIM*DIM matrix then scans out, after a start state, at one word per cycle
// while out_stall is low; loads and scans of matrices can overlap across banks.
// First result goes via the run queue, walker start, read stage and output register.
// Synchronous active-low reset clears load counters, queue, valid flags; memory holds.
// in_stall rises while both banks hold unscanned matrices; out_stall freezes the scan.
`default_nettype none

module spiral_order_matrix_scan_core #(
  parameter int DIM = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [sosc_pkg::VAL_W-1:0] in_elem_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [sosc_pkg::VAL_W-1:0]      out_value,
  output logic [sosc_pkg::RC_W-1:0]       out_row,
  output logic [sosc_pkg::RC_W-1:0]       out_col,
  output logic                            out_run_last
);

  sosc_pkg::wr_req_t  wr;
  sosc_pkg::run_tok_t tok;
  logic               bank_free;
  logic               q_pop;
  logic               q_empty;
  logic               q_bank;

  sosc_front #(.DIM(DIM)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_elem_value (in_elem_value),
    .bank_free     (bank_free),
    .wr            (wr),
    .tok           (tok)
  );

  sosc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_bank (q_bank)
  );

  sosc_back #(.DIM(DIM)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr           (wr),
    .q_empty      (q_empty),
    .q_bank       (q_bank),
    .q_pop        (q_pop),
    .bank_free    (bank_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire

FILE: hdl/sosc_checker.sv
// Port-level checks for the spiral-order matrix scanner and their binding.
`default_nettype none

module sosc_checker #(
  parameter int DIM = 5
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [sosc_pkg::VAL_W-1:0] out_value,
  input wire logic [sosc_pkg::RC_W-1:0]  out_row,
  input wire logic [sosc_pkg::RC_W-1:0]  out_col,
  input wire logic                       out_run_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_row)
                               && $stable(out_col) && $stable(out_run_last))
    else $error("stalled output word changed");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_row) < DIM) && (int'(out_col) < DIM))
    else $error("row or column outside matrix");

  a_last_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |->
      (int'(out_row) == DIM / 2) && (int'(out_col) == (DIM - 1) / 2))
    else $error("run ended away from spiral end point");

  a_no_in_stall_reset: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind spiral_order_matrix_scan_core sosc_checker #(.DIM(DIM)) u_sosc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_value    (out_value),
  .out_row      (out_row),
  .out_col      (out_col),
  .out_run_last (out_run_last)
);

`default_nettype wire

FILE: verif/tb_spiral_order_matrix_scan_core.sv
// Testbench for spiral_order_matrix_scan_core: random and directed matrices in spiral order.
`timescale 1ns / 100ps

module tb_spiral_order_matrix_scan_core;

  localparam int DIM        = 5;
  localparam int CELLS      = DIM * DIM;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AFTER = 60;

  typedef struct packed {
    logic [sosc_pkg::VAL_W-1:0] value;
    sosc_pkg::rc_t              row;
    sosc_pkg::rc_t              col;
    logic                       last;
  } spiral_word_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                       clk;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic [sosc_pkg::VAL_W-1:0] in_elem_value = '0;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic [sosc_pkg::VAL_W-1:0] out_value;
  logic [sosc_pkg::RC_W-1:0]  out_row;
  logic [sosc_pkg::RC_W-1:0]  out_col;
  logic                       out_run_last;

  logic [sosc_pkg::VAL_W-1:0] elem_queue[$];
  spiral_word_t               spiral_q[$];
  logic [sosc_pkg::VAL_W-1:0] matrix_mem[CELLS];
  int                         fill_count  = 0;
  int                         words_in    = 0;
  int                         mismatches  = 0;
  int                         idle_cycles = 0;

  spiral_order_matrix_scan_core #(
    .DIM(DIM)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_elem_value(in_elem_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_run_last (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic spiral_word_t cell_word(int r, int c, int k);
    spiral_word_t w;
    w.value = matrix_mem[r * DIM + c];
    w.row   = sosc_pkg::rc_t'(r);
    w.col   = sosc_pkg::rc_t'(c);
    w.last  = (k == CELLS - 1);
    return w;
  endfunction

  task automatic load_element(input logic [sosc_pkg::VAL_W-1:0] v);
    int top, bottom, lft, rgt, k, i;
    matrix_mem[fill_count] = v;
    if (fill_count != CELLS - 1) begin
      fill_count++;
      return;
    end
    fill_count = 0;
    top = 0;
    bottom = DIM - 1;
    lft = 0;
    rgt = DIM - 1;
    k = 0;
    while (top <= bottom && lft <= rgt) begin
      for (i = lft; i <= rgt; i++) begin
        spiral_q.push_back(cell_word(top, i, k));
        k++;
      end
      top++;
      for (i = top; i <= bottom; i++) begin
        spiral_q.push_back(cell_word(i, rgt, k));
        k++;
      end
      rgt--;
      if (top <= bottom) begin
        for (i = rgt; i >= lft; i--) begin
          spiral_q.push_back(cell_word(bottom, i, k));
          k++;
        end
        bottom--;
      end
      if (lft <= rgt) begin
        for (i = bottom; i >= top; i--) begin
          spiral_q.push_back(cell_word(i, lft, k));
          k++;
        end
        lft++;
      end
    end
  endtask

  function automatic logic [sosc_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 15));
      3: return -32'($urandom_range(1, 15));
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (elem_queue.size() != 0 || in_valid || spiral_q.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (elem_queue.size() != 0) begin
        in_elem_value <= elem_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    int          hold_left;
    int          mode_left;
    int          phase;
    bit          long_hold_done;
    stall_mode_t stall_mode;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      phase = 0;
      long_hold_done = 1'b0;
      stall_mode = STALL_NONE;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && words_in >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end else begin
        mode_left--;
      end
      phase++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (phase % 5 < 2);
      endcase
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    spiral_word_t got;
    spiral_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.value = out_value;
        got.row   = out_row;
        got.col   = out_col;
        got.last  = out_run_last;
        if (spiral_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: value %h row %0d col %0d last %b",
                     got.value, got.row, got.col, got.last);
          mismatches++;
        end else begin
          want = spiral_q.pop_front();
          if (got.value !== want.value || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last) begin
            if (mismatches < 10)
              $display("mismatch: expected value %h row %0d col %0d last %b,",
                       want.value, want.row, want.col, want.last,
                       " got value %h row %0d col %0d last %b",
                       got.value, got.row, got.col, got.last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        load_element(in_elem_value);
        words_in <= words_in + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_spiral_order_matrix_scan_core failed");
      $finish;
    end
  end

  initial begin
    int                         i;
    logic [sosc_pkg::VAL_W-1:0] v;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (i = 0; i < CELLS; i++) begin
      case (i)
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        3: v = 32'hffff_ffff;
        4: v = 32'h0000_0001;
        5: v = 32'hffff_fffe;
        6: v = 32'h5555_5555;
        7: v = 32'haaaa_aaaa;
        default: v = 32'ha5a5_0000 | 32'(i);
      endcase
      elem_queue.push_back(v);
    end
    wait_drained();
    for (i = 0; i < 4 * CELLS; i++) elem_queue.push_back(pick_value());
    wait_drained();
    for (i = 0; i < 3 * CELLS; i++) elem_queue.push_back(pick_value());
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && spiral_q.size() == 0) begin
      $display("tb_spiral_order_matrix_scan_core passed");
    end else begin
      $display("tb_spiral_order_matrix_scan_core failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sosc_pkg.sv
hdl/sosc_front.sv
hdl/sosc_fifo.sv
hdl/sosc_back.sv
hdl/spiral_order_matrix_scan_core.sv
hdl/sosc_checker.sv
verif/tb_spiral_order_matrix_scan_core.sv
